FILE: rtl/core/tsc_pkg.sv
// Package for the 2-SAT component checker: shared constants, controller
// states, datapath commands and the status bundle.
// No dependencies.
package tsc_pkg;

  localparam int unsigned MaxVarsDef    = 1024;
  localparam int unsigned MaxClausesDef = 4096;
  localparam int unsigned LitW          = 12;
  localparam int unsigned NumVarsW      = 11;
  localparam logic [NumVarsW-1:0] NumVarsReset = 11'd1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_RDA,
    ST_LD_WRA,
    ST_LD_RDB,
    ST_LD_WRB,
    ST_SC_RD,
    ST_SC_CHK,
    ST_ENTER,
    ST_ENT2,
    ST_EDGE,
    ST_ED2,
    ST_ED3,
    ST_FIN,
    ST_POP_RD,
    ST_POP_WR,
    ST_RET,
    ST_RET2,
    ST_RET3,
    ST_CMP_RDA,
    ST_CMP_RDB,
    ST_CMP_CHK,
    ST_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_ACCEPT,
    OP_LD_RDA,
    OP_LD_WRA,
    OP_LD_RDB,
    OP_LD_WRB,
    OP_SC_RD,
    OP_SC_CHK,
    OP_ENTER,
    OP_ENT2,
    OP_EDGE,
    OP_ED2,
    OP_ED3,
    OP_POP_RD,
    OP_POP_WR,
    OP_RET,
    OP_RET2,
    OP_RET3,
    OP_CMP_RDA,
    OP_CMP_RDB,
    OP_CMP_CHK,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    logic in_last;
    logic last;
    logic clr_last;
    logic root_done;
    logic unvisited;
    logic e_zero;
    logic low_eq_ord;
    logic pop_hit;
    logic csp_zero;
    logic cmp_done;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/core/tsc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tsc_ctrl.sv
// Sequencer for the 2-SAT checker: loads clauses, walks the components,
// compares literal pairs and clears the stores. Uses tsc_pkg.
module tsc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tsc_pkg::status_t status_i,
  output tsc_pkg::cmd_t    cmd_o
);

  tsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = tsc_pkg::OP_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      tsc_pkg::ST_CLEAR: begin
        cmd_o.op = tsc_pkg::OP_CLEAR;
        if (status_i.clr_last) state_d = tsc_pkg::ST_IDLE;
      end
      tsc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = tsc_pkg::OP_ACCEPT;
          if (status_i.in_ok) begin
            state_d = tsc_pkg::ST_LD_RDA;
          end else if (status_i.in_last) begin
            state_d = tsc_pkg::ST_SC_RD;
          end
        end
      end
      tsc_pkg::ST_LD_RDA: begin
        cmd_o.op = tsc_pkg::OP_LD_RDA;
        state_d  = tsc_pkg::ST_LD_WRA;
      end
      tsc_pkg::ST_LD_WRA: begin
        cmd_o.op = tsc_pkg::OP_LD_WRA;
        state_d  = tsc_pkg::ST_LD_RDB;
      end
      tsc_pkg::ST_LD_RDB: begin
        cmd_o.op = tsc_pkg::OP_LD_RDB;
        state_d  = tsc_pkg::ST_LD_WRB;
      end
      tsc_pkg::ST_LD_WRB: begin
        cmd_o.op = tsc_pkg::OP_LD_WRB;
        state_d  = status_i.last ? tsc_pkg::ST_SC_RD : tsc_pkg::ST_IDLE;
      end
      tsc_pkg::ST_SC_RD: begin
        cmd_o.op = tsc_pkg::OP_SC_RD;
        state_d  = status_i.root_done ? tsc_pkg::ST_CMP_RDA : tsc_pkg::ST_SC_CHK;
      end
      tsc_pkg::ST_SC_CHK: begin
        cmd_o.op = tsc_pkg::OP_SC_CHK;
        state_d  = status_i.unvisited ? tsc_pkg::ST_ENTER : tsc_pkg::ST_SC_RD;
      end
      tsc_pkg::ST_ENTER: begin
        cmd_o.op = tsc_pkg::OP_ENTER;
        state_d  = tsc_pkg::ST_ENT2;
      end
      tsc_pkg::ST_ENT2: begin
        cmd_o.op = tsc_pkg::OP_ENT2;
        state_d  = tsc_pkg::ST_EDGE;
      end
      tsc_pkg::ST_EDGE: begin
        if (status_i.e_zero) begin
          state_d = tsc_pkg::ST_FIN;
        end else begin
          cmd_o.op = tsc_pkg::OP_EDGE;
          state_d  = tsc_pkg::ST_ED2;
        end
      end
      tsc_pkg::ST_ED2: begin
        cmd_o.op = tsc_pkg::OP_ED2;
        state_d  = tsc_pkg::ST_ED3;
      end
      tsc_pkg::ST_ED3: begin
        cmd_o.op = tsc_pkg::OP_ED3;
        state_d  = status_i.unvisited ? tsc_pkg::ST_ENTER : tsc_pkg::ST_EDGE;
      end
      tsc_pkg::ST_FIN: begin
        state_d = status_i.low_eq_ord ? tsc_pkg::ST_POP_RD : tsc_pkg::ST_RET;
      end
      tsc_pkg::ST_POP_RD: begin
        cmd_o.op = tsc_pkg::OP_POP_RD;
        state_d  = tsc_pkg::ST_POP_WR;
      end
      tsc_pkg::ST_POP_WR: begin
        cmd_o.op = tsc_pkg::OP_POP_WR;
        state_d  = status_i.pop_hit ? tsc_pkg::ST_RET : tsc_pkg::ST_POP_RD;
      end
      tsc_pkg::ST_RET: begin
        cmd_o.op = tsc_pkg::OP_RET;
        state_d  = status_i.csp_zero ? tsc_pkg::ST_SC_RD : tsc_pkg::ST_RET2;
      end
      tsc_pkg::ST_RET2: begin
        cmd_o.op = tsc_pkg::OP_RET2;
        state_d  = tsc_pkg::ST_RET3;
      end
      tsc_pkg::ST_RET3: begin
        cmd_o.op = tsc_pkg::OP_RET3;
        state_d  = tsc_pkg::ST_EDGE;
      end
      tsc_pkg::ST_CMP_RDA: begin
        if (status_i.cmp_done) begin
          state_d = tsc_pkg::ST_OUT;
        end else begin
          cmd_o.op = tsc_pkg::OP_CMP_RDA;
          state_d  = tsc_pkg::ST_CMP_RDB;
        end
      end
      tsc_pkg::ST_CMP_RDB: begin
        cmd_o.op = tsc_pkg::OP_CMP_RDB;
        state_d  = tsc_pkg::ST_CMP_CHK;
      end
      tsc_pkg::ST_CMP_CHK: begin
        cmd_o.op = tsc_pkg::OP_CMP_CHK;
        state_d  = tsc_pkg::ST_CMP_RDA;
      end
      tsc_pkg::ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = tsc_pkg::OP_OUT;
          state_d  = tsc_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_d = tsc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

FILE: rtl/core/tsc_datapath.sv
// Datapath of the 2-SAT checker: edge lists, search stacks, per-node stores,
// counters and the output register. Uses tsc_pkg and tsc_ram.
module tsc_datapath #(
  parameter int unsigned MaxVars    = tsc_pkg::MaxVarsDef,
  parameter int unsigned MaxClauses = tsc_pkg::MaxClausesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tsc_pkg::cmd_t                  cmd_i,
  output tsc_pkg::status_t               status_o,
  input  logic signed [tsc_pkg::LitW-1:0] lit_a_i,
  input  logic signed [tsc_pkg::LitW-1:0] lit_b_i,
  input  logic                           last_clause_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tsc_pkg::NumVarsW-1:0]   cfg_data_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic                           satisfiable_o,
  output logic                           input_error_o
);

  localparam int unsigned Nodes = 2 * MaxVars;
  localparam int unsigned Edges = 2 * MaxClauses;
  localparam int unsigned NW    = $clog2(Nodes);
  localparam int unsigned EAW   = $clog2(Edges);
  localparam int unsigned EPW   = $clog2(Edges + 1);
  localparam int unsigned VW    = $clog2(Nodes + 1);
  localparam int unsigned NVW   = $clog2(MaxVars + 1);
  localparam int unsigned LW    = tsc_pkg::LitW;
  localparam int unsigned CW    = (NVW > LW) ? NVW : LW;

  // Configuration and active variable count.
  logic [tsc_pkg::NumVarsW-1:0] cfg_q;
  logic [NVW-1:0] nv;

  always_comb begin
    if (32'(cfg_q) > MaxVars) nv = NVW'(MaxVars);
    else nv = NVW'(cfg_q);
  end

  // Control registers.
  logic [EPW-1:0] ec_q;
  logic [VW-1:0]  vc_q, cc_q, nsp_q, csp_q;
  logic [NVW:0]   r_q;
  logic [NVW-1:0] i_q;
  logic [NW-1:0]  clr_q;
  logic           top_q, err_q, sat_q, last_q;
  logic           out_valid_q, out_sat_q, out_err_q;

  // Payload registers.
  logic [NW-1:0]  fa_q, fb_q, ta_q, tb_q, x_q, y_q;
  logic [EPW-1:0] e_q;
  logic [VW-1:0]  lowx_q, ordx_q, ca_q;

  // RAM ports.
  logic           head_we, head_re, vis_we, vis_re, low_we, low_re;
  logic           comp_we, comp_re, edg_we, edg_re, nstk_we, nstk_re, call_we, call_re;
  logic [NW-1:0]  head_wa, head_ra, vis_wa, vis_ra, low_wa, low_ra;
  logic [NW-1:0]  comp_wa, comp_ra, nstk_wa, nstk_ra, call_wa, call_ra;
  logic [EAW-1:0] edg_wa, edg_ra;
  logic [EPW-1:0] head_wd, head_rd, nxt_wd, nxt_rd, cedge_rd;
  logic [VW-1:0]  vis_wd, vis_rd, low_rd, comp_wd, comp_rd;
  logic [NW-1:0]  tgt_wd, tgt_rd, nstk_rd, cnode_rd;

  tsc_ram #(.Width(EPW), .Depth(Nodes)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .re_i(head_re), .raddr_i(head_ra), .rdata_o(head_rd)
  );
  tsc_ram #(.Width(VW), .Depth(Nodes)) u_visit (
    .clk_i, .we_i(vis_we), .waddr_i(vis_wa), .wdata_i(vis_wd),
    .re_i(vis_re), .raddr_i(vis_ra), .rdata_o(vis_rd)
  );
  tsc_ram #(.Width(VW), .Depth(Nodes)) u_low (
    .clk_i, .we_i(low_we), .waddr_i(low_wa), .wdata_i(lowx_q),
    .re_i(low_re), .raddr_i(low_ra), .rdata_o(low_rd)
  );
  tsc_ram #(.Width(VW), .Depth(Nodes)) u_comp (
    .clk_i, .we_i(comp_we), .waddr_i(comp_wa), .wdata_i(comp_wd),
    .re_i(comp_re), .raddr_i(comp_ra), .rdata_o(comp_rd)
  );
  tsc_ram #(.Width(NW), .Depth(Edges)) u_tgt (
    .clk_i, .we_i(edg_we), .waddr_i(edg_wa), .wdata_i(tgt_wd),
    .re_i(edg_re), .raddr_i(edg_ra), .rdata_o(tgt_rd)
  );
  tsc_ram #(.Width(EPW), .Depth(Edges)) u_nxt (
    .clk_i, .we_i(edg_we), .waddr_i(edg_wa), .wdata_i(nxt_wd),
    .re_i(edg_re), .raddr_i(edg_ra), .rdata_o(nxt_rd)
  );
  tsc_ram #(.Width(NW), .Depth(Nodes)) u_nstk (
    .clk_i, .we_i(nstk_we), .waddr_i(nstk_wa), .wdata_i(y_q),
    .re_i(nstk_re), .raddr_i(nstk_ra), .rdata_o(nstk_rd)
  );
  tsc_ram #(.Width(NW), .Depth(Nodes)) u_cnode (
    .clk_i, .we_i(call_we), .waddr_i(call_wa), .wdata_i(x_q),
    .re_i(call_re), .raddr_i(call_ra), .rdata_o(cnode_rd)
  );
  tsc_ram #(.Width(EPW), .Depth(Nodes)) u_cedge (
    .clk_i, .we_i(call_we), .waddr_i(call_wa), .wdata_i(e_q),
    .re_i(call_re), .raddr_i(call_ra), .rdata_o(cedge_rd)
  );

  // Literal decode.
  logic [LW-1:0] la, lb, mag_a, mag_b;
  logic [NW-1:0] node_a, node_b;
  logic          ok_a, ok_b, ovf, in_ok;

  always_comb begin
    la     = lit_a_i;
    lb     = lit_b_i;
    mag_a  = la[LW-1] ? (LW'(0) - la) : la;
    mag_b  = lb[LW-1] ? (LW'(0) - lb) : lb;
    ok_a   = (mag_a != '0) && (CW'(mag_a) <= CW'(nv));
    ok_b   = (mag_b != '0) && (CW'(mag_b) <= CW'(nv));
    node_a = NW'({mag_a - LW'(1), la[LW-1]});
    node_b = NW'({mag_b - LW'(1), lb[LW-1]});
    ovf    = (32'(ec_q) + 32'd2) > Edges;
    in_ok  = ok_a && ok_b && !ovf;
  end

  // Memory port steering.
  always_comb begin
    head_we = 1'b0; head_re = 1'b0; head_wa = fa_q; head_ra = fa_q; head_wd = '0;
    vis_we  = 1'b0; vis_re  = 1'b0; vis_wa  = y_q;  vis_ra  = tgt_rd; vis_wd = '0;
    low_we  = 1'b0; low_re  = 1'b0; low_wa  = x_q;  low_ra  = cnode_rd;
    comp_we = 1'b0; comp_re = 1'b0; comp_wa = nstk_rd; comp_ra = tgt_rd; comp_wd = cc_q;
    edg_we  = 1'b0; edg_re  = 1'b0; edg_wa  = EAW'(ec_q); edg_ra = EAW'(e_q - EPW'(1));
    tgt_wd  = tb_q; nxt_wd  = head_rd;
    nstk_we = 1'b0; nstk_re = 1'b0; nstk_wa = NW'(nsp_q);
    nstk_ra = NW'(nsp_q - VW'(1));
    call_we = 1'b0; call_re = 1'b0; call_wa = NW'(csp_q);
    call_ra = NW'(csp_q - VW'(1));
    case (cmd_i.op)
      tsc_pkg::OP_CLEAR: begin
        head_we = 1'b1; head_wa = clr_q;
        vis_we  = 1'b1; vis_wa  = clr_q;
        comp_we = 1'b1; comp_wa = clr_q; comp_wd = '0;
      end
      tsc_pkg::OP_LD_RDA: head_re = 1'b1;
      tsc_pkg::OP_LD_WRA: begin
        edg_we  = 1'b1;
        head_we = 1'b1; head_wd = ec_q + EPW'(1);
      end
      tsc_pkg::OP_LD_RDB: begin
        head_re = 1'b1; head_ra = fb_q;
      end
      tsc_pkg::OP_LD_WRB: begin
        edg_we  = 1'b1; tgt_wd = ta_q;
        head_we = 1'b1; head_wa = fb_q; head_wd = ec_q + EPW'(1);
      end
      tsc_pkg::OP_SC_RD: begin
        vis_re = 1'b1; vis_ra = NW'(r_q);
      end
      tsc_pkg::OP_ENTER: begin
        vis_we  = 1'b1; vis_wd = vc_q + VW'(1);
        nstk_we = 1'b1;
        head_re = 1'b1; head_ra = y_q;
        if (top_q) begin
          call_we = 1'b1;
          low_we  = 1'b1;
        end
      end
      tsc_pkg::OP_EDGE: edg_re = 1'b1;
      tsc_pkg::OP_ED2: begin
        vis_re  = 1'b1;
        comp_re = 1'b1;
      end
      tsc_pkg::OP_POP_RD: nstk_re = 1'b1;
      tsc_pkg::OP_POP_WR: comp_we = 1'b1;
      tsc_pkg::OP_RET: call_re = !(csp_q == '0);
      tsc_pkg::OP_RET2: begin
        low_re = 1'b1;
        vis_re = 1'b1; vis_ra = cnode_rd;
      end
      tsc_pkg::OP_CMP_RDA: begin
        comp_re = 1'b1; comp_ra = NW'({i_q, 1'b0});
      end
      tsc_pkg::OP_CMP_RDB: begin
        comp_re = 1'b1; comp_ra = NW'({i_q, 1'b1});
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= tsc_pkg::NumVarsReset;
      ec_q        <= '0;
      vc_q        <= '0;
      cc_q        <= VW'(1);
      nsp_q       <= '0;
      csp_q       <= '0;
      r_q         <= '0;
      i_q         <= '0;
      clr_q       <= '0;
      top_q       <= 1'b0;
      err_q       <= 1'b0;
      sat_q       <= 1'b1;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_sat_q   <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        tsc_pkg::OP_CLEAR: begin
          clr_q <= (clr_q == NW'(Nodes - 1)) ? '0 : clr_q + NW'(1);
          ec_q  <= '0;
          vc_q  <= '0;
          cc_q  <= VW'(1);
          nsp_q <= '0;
          csp_q <= '0;
          r_q   <= '0;
          i_q   <= '0;
          top_q <= 1'b0;
          err_q <= 1'b0;
          sat_q <= 1'b1;
        end
        tsc_pkg::OP_ACCEPT: begin
          last_q <= last_clause_i;
          if (!in_ok) err_q <= 1'b1;
        end
        tsc_pkg::OP_LD_WRA, tsc_pkg::OP_LD_WRB: ec_q <= ec_q + EPW'(1);
        tsc_pkg::OP_SC_CHK: begin
          if (vis_rd != '0) r_q <= r_q + (NVW+1)'(1);
        end
        tsc_pkg::OP_ENTER: begin
          vc_q  <= vc_q + VW'(1);
          nsp_q <= nsp_q + VW'(1);
          top_q <= 1'b1;
          if (top_q) csp_q <= csp_q + VW'(1);
        end
        tsc_pkg::OP_POP_RD: nsp_q <= nsp_q - VW'(1);
        tsc_pkg::OP_POP_WR: begin
          if (nstk_rd == x_q) cc_q <= cc_q + VW'(1);
        end
        tsc_pkg::OP_RET: begin
          if (csp_q == '0) begin
            top_q <= 1'b0;
            r_q   <= r_q + (NVW+1)'(1);
          end else begin
            csp_q <= csp_q - VW'(1);
          end
        end
        tsc_pkg::OP_CMP_CHK: begin
          if (ca_q == comp_rd) sat_q <= 1'b0;
          i_q <= i_q + NVW'(1);
        end
        tsc_pkg::OP_OUT: begin
          out_valid_q <= 1'b1;
          out_sat_q   <= sat_q;
          out_err_q   <= err_q;
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the current search frame and the latched clause.
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tsc_pkg::OP_ACCEPT: begin
        fa_q <= node_a ^ NW'(1);
        fb_q <= node_b ^ NW'(1);
        ta_q <= node_a;
        tb_q <= node_b;
      end
      tsc_pkg::OP_SC_CHK: y_q <= NW'(r_q);
      tsc_pkg::OP_ENTER: begin
        x_q    <= y_q;
        lowx_q <= vc_q + VW'(1);
        ordx_q <= vc_q + VW'(1);
      end
      tsc_pkg::OP_ENT2: e_q <= head_rd;
      tsc_pkg::OP_ED2: begin
        y_q <= tgt_rd;
        e_q <= nxt_rd;
      end
      tsc_pkg::OP_ED3: begin
        // A visited node still on the stack may lower the current low link.
        if ((vis_rd != '0) && (comp_rd == '0) && (vis_rd < lowx_q)) lowx_q <= vis_rd;
      end
      tsc_pkg::OP_RET3: begin
        x_q    <= cnode_rd;
        e_q    <= cedge_rd;
        ordx_q <= vis_rd;
        if (low_rd < lowx_q) lowx_q <= low_rd;
      end
      tsc_pkg::OP_CMP_RDB: ca_q <= comp_rd;
      default: ;
    endcase
  end

  always_comb begin
    status_o.in_ok      = in_ok;
    status_o.in_last    = last_clause_i;
    status_o.last       = last_q;
    status_o.clr_last   = (clr_q == NW'(Nodes - 1));
    status_o.root_done  = (r_q == {nv, 1'b0});
    status_o.unvisited  = (vis_rd == '0);
    status_o.e_zero     = (e_q == '0);
    status_o.low_eq_ord = (lowx_q == ordx_q);
    status_o.pop_hit    = (nstk_rd == x_q);
    status_o.csp_zero   = (csp_q == '0);
    status_o.cmp_done   = (i_q == nv);
    status_o.out_busy   = out_valid_q;
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign satisfiable_o = out_sat_q;
  assign input_error_o = out_err_q;

  a_nsp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nsp_q) <= Nodes) else $error("node stack overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == tsc_pkg::OP_POP_RD |-> nsp_q != '0) else $error("pop from empty stack");
  a_edge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ec_q) <= Edges) else $error("edge count overflow");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == tsc_pkg::OP_OUT |=> out_valid_q) else $error("result not registered");

endmodule

FILE: rtl/core/two_sat_scc_checker.sv
// Top level of the 2-SAT checker: controller plus datapath.
// Uses tsc_pkg, tsc_ctrl, tsc_datapath (and tsc_ram below it).
//
// Usage: each input item is one clause (lit_a OR lit_b) with signed literals.
// An item is taken when in_valid_i is high and in_stall_o is low. A valid
// clause is accepted, then its two implication edges are stored, each by a
// read and a write of the head store. An invalid one only sets the error
// flag. The item with last_clause_i set starts the component search over
// N = 2*num_vars nodes and the stored edges; each node and edge store has a
// single read port. One result item then appears on out_valid_o with
// satisfiable_o and input_error_o; it stays in its output register while
// out_stall_i is high. After the result is registered, and after reset, the
// block clears the head, visit and component stores (2*MaxVars entries
// each) with in_stall_o high. num_vars is to be written by the user on the
// configuration channel (always ready) only while the block is idle; the
// block itself does not enforce this. Reset sets num_vars to 1.
module two_sat_scc_checker #(
  parameter int unsigned MaxVars    = tsc_pkg::MaxVarsDef,
  parameter int unsigned MaxClauses = tsc_pkg::MaxClausesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [tsc_pkg::LitW-1:0] lit_a_i,
  input  logic signed [tsc_pkg::LitW-1:0] lit_b_i,
  input  logic                            last_clause_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tsc_pkg::NumVarsW-1:0]    cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            satisfiable_o,
  output logic                            input_error_o
);

  tsc_pkg::cmd_t    cmd;
  tsc_pkg::status_t status;

  tsc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .status_i (status),
    .cmd_o    (cmd)
  );

  tsc_datapath #(
    .MaxVars    (MaxVars),
    .MaxClauses (MaxClauses)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i    (cmd),
    .status_o (status),
    .lit_a_i,
    .lit_b_i,
    .last_clause_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .out_stall_i,
    .out_valid_o,
    .satisfiable_o,
    .input_error_o
  );

endmodule
